>>> rtl/core/fmce_pkg.sv
// fmce_pkg: shared types and constants of the faulty memory cell emulator
// field widths, action and fault type codes, fault table entry layout
// no dependencies
`default_nettype none

package fmce_pkg;

  localparam int ADDR_W    = 10;
  localparam int DATA_W    = 16;
  localparam int SLOT_W    = 4;
  localparam int TYPE_W    = 3;
  localparam int CELL_W    = 14;
  localparam int S_TDATA_W = 64;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 16;

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_CLEAR = 2'd1,
    ACT_WRITE = 2'd2,
    ACT_READ  = 2'd3
  } act_e;

  typedef enum logic [TYPE_W-1:0] {
    FT_STUCK = 3'd0,
    FT_TRANS = 3'd1,
    FT_INV   = 3'd2,
    FT_IDEM  = 3'd3,
    FT_STATE = 3'd4,
    FT_ADDR  = 3'd5
  } fault_type_e;

  typedef enum logic [1:0] {
    OP_GET = 2'd0,
    OP_SET = 2'd1,
    OP_INV = 2'd2
  } cell_op_e;

  typedef enum logic [1:0] {
    RET_LOAD  = 2'd0,
    RET_STATE = 2'd1,
    RET_AGGR  = 2'd2
  } ret_e;

  typedef struct packed {
    logic [TYPE_W-1:0] ftype;
    logic [CELL_W-1:0] victim;
    logic              vval;
    logic [CELL_W-1:0] aggr;
    logic              aval;
  } fault_ent_t;

endpackage

`default_nettype wire

>>> rtl/core/faulty_memory_cell_emulator.sv
// faulty_memory_cell_emulator: word memory with an injected cell fault table
// single module, sequenced over one shared cell access unit (reciprocal split + rmw)
// depends on fmce_pkg
`default_nettype none

// A memory of WORDS words of WORD_BITS bits plus a table of FAULT_SLOTS cell
// faults (stuck-at, transition, inversion/idempotent/state coupling, address
// fault). Every word taken on the slave side gives exactly one word on the
// master side: the stored word at word_address after the action (zero when
// the address is out of range). After reset the block sweeps every word of
// the memory to zero before it raises s_axis_tready. One word is worked on
// at a time: a write walks the word bit by bit, and each bit that changes
// scans the fault table one slot per cycle. Whenever a fault touches another
// cell (stuck-at load, coupling, address fault, state coupling aggressor
// read) the shared cell unit splits the 14-bit cell number into word and bit
// by a reciprocal multiplication and then does a read-modify-write of the
// single-port memory (a plain read for the aggressor read; it works on the
// live copy when the cell lies in the word being written). A finished result
// waits in the output register, so the next word can be taken while it is
// still pending.
module faulty_memory_cell_emulator
  import fmce_pkg::*;
#(
  parameter int WORD_BITS   = 16,
  parameter int WORDS       = 1024,
  parameter int FAULT_SLOTS = 16
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   s_axis_tvalid,
  output logic                  s_axis_tready,
  // word_address, write_data, fault_slot, fault_type, victim_cell,
  // victim_value, aggressor_cell, aggressor_value, zero pad (lowest first)
  input  wire [S_TDATA_W-1:0]   s_axis_tdata,
  // action
  input  wire [S_TUSER_W-1:0]   s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  wire                   m_axis_tready,
  // word_data
  output logic [M_TDATA_W-1:0]  m_axis_tdata
);

  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int BW    = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
  localparam int BCW   = $clog2(WORD_BITS + 1);
  localparam int RW    = $clog2(WORD_BITS) + 2;
  localparam int SIW   = (FAULT_SLOTS > 1) ? $clog2(FAULT_SLOTS) : 1;
  localparam int SCW   = $clog2(FAULT_SLOTS + 1);
  localparam int CELLW = ADDR_W + $clog2(WORD_BITS);
  localparam int CMPW  = (CELLW > CELL_W) ? CELLW : CELL_W;
  localparam int DCW   = 1;
  // exact cell / WORD_BITS for any 14-bit cell: (cell * RECIP) >> RSH
  localparam int RSH   = CELL_W + BW;
  localparam int RCW   = RSH + 1;
  localparam int PW    = CELL_W + RCW;
  localparam logic [63:0] RECIP_L =
    ((64'd1 << RSH) + 64'(WORD_BITS) - 64'd1) / 64'(WORD_BITS);
  localparam logic [RCW-1:0] RECIP = RCW'(RECIP_L);

  // one-hot sequencer
  typedef enum logic [14:0] {
    S_CLR  = 15'h0001,
    S_IDLE = 15'h0002,
    S_EXEC = 15'h0004,
    S_WRW  = 15'h0008,
    S_BIT  = 15'h0010,
    S_SCAN = 15'h0020,
    S_DEC  = 15'h0040,
    S_DIV  = 15'h0080,
    S_CLOC = 15'h0100,
    S_CRD  = 15'h0200,
    S_NEXT = 15'h0400,
    S_WB   = 15'h0800,
    S_ORD  = 15'h1000,
    S_ORW  = 15'h2000,
    S_OUT  = 15'h4000
  } state_e;

  // storage
  logic [WORD_BITS-1:0] mem [WORDS];
  fault_ent_t           tab [FAULT_SLOTS];
  logic                 vld_q [FAULT_SLOTS];

  // control registers
  state_e               state_q, state_d;
  logic [AW-1:0]        clr_cnt_q, clr_cnt_d;
  logic                 pv_q, pv_d;
  logic                 out_valid_q;
  logic [DATA_W-1:0]    out_data_q;

  // captured input word
  act_e                 act_q;
  logic [ADDR_W-1:0]    addr_q;
  logic [WORD_BITS-1:0] wd_q;
  logic [SLOT_W-1:0]    slot_q;
  fault_ent_t           ent_q;

  // write walk
  logic [WORD_BITS-1:0] old_q, old_d;
  logic [WORD_BITS-1:0] cur_q, cur_d;
  logic [CELLW-1:0]     base_q, base_d;
  logic [CMPW-1:0]      cell_q, cell_d;
  logic [BCW-1:0]       b_q, b_d;
  logic [SCW-1:0]       sc_q, sc_d;
  logic                 vf_q, vf_d, af_q, af_d;
  fault_ent_t           vent_q, vent_d, aent_q, aent_d;
  logic                 wbit_q, wbit_d;
  fault_ent_t           tab_rd_q;
  logic                 vrd_q;

  // shared cell access unit
  logic [CELL_W-1:0]    sh_q, sh_d;
  logic [RW-1:0]        rem_q, rem_d;
  logic [CELL_W-1:0]    quo_q, quo_d;
  logic [DCW-1:0]       dcnt_q, dcnt_d;
  cell_op_e             op_q, op_d;
  logic                 opv_q, opv_d;
  ret_e                 ret_q, ret_d;

  logic [DATA_W-1:0]    res_q, res_d;
  logic [WORD_BITS-1:0] rdata_q;

  // memory port
  logic                 mem_we, mem_re;
  logic [AW-1:0]        mem_wa, mem_ra;
  logic [WORD_BITS-1:0] mem_wd;

  logic                 in_acc, out_load, addr_ok, slot_ok, load_ok;
  logic                 cop_start, cop_done;
  logic [CELL_W-1:0]    cop_cell;
  cell_op_e             cop_op;
  logic                 cop_val;
  ret_e                 cop_ret;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid & s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign addr_ok       = (32'(addr_q) < WORDS);
  assign slot_ok       = (32'(slot_q) < FAULT_SLOTS);
  assign load_ok       = slot_ok && (ent_q.ftype <= FT_ADDR);

  always_comb begin
    logic [BW-1:0]        bi;
    logic [BW-1:0]        ci;
    logic [PW-1:0]        prod;
    logic [WORD_BITS-1:0] wtmp;
    logic                 g;
    logic                 nv, ov, vm, am;

    state_d   = state_q;
    clr_cnt_d = clr_cnt_q;
    pv_d      = pv_q;
    old_d     = old_q;
    cur_d     = cur_q;
    base_d    = base_q;
    cell_d    = cell_q;
    b_d       = b_q;
    sc_d      = sc_q;
    vf_d      = vf_q;
    af_d      = af_q;
    vent_d    = vent_q;
    aent_d    = aent_q;
    wbit_d    = wbit_q;
    sh_d      = sh_q;
    rem_d     = rem_q;
    quo_d     = quo_q;
    dcnt_d    = dcnt_q;
    op_d      = op_q;
    opv_d     = opv_q;
    ret_d     = ret_q;
    res_d     = res_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_wa    = AW'(addr_q);
    mem_ra    = AW'(addr_q);
    mem_wd    = cur_q;
    out_load  = 1'b0;
    cop_start = 1'b0;
    cop_done  = 1'b0;
    cop_cell  = ent_q.victim;
    cop_op    = OP_SET;
    cop_val   = ent_q.vval;
    cop_ret   = RET_LOAD;
    g         = 1'b0;
    bi        = b_q[BW-1:0];
    ci        = rem_q[BW-1:0];
    nv        = wd_q[bi];
    ov        = old_q[bi];
    prod      = PW'(sh_q) * PW'(RECIP);
    wtmp      = rdata_q;
    vm        = vrd_q && (tab_rd_q.ftype != FT_ADDR) &&
                (CMPW'(tab_rd_q.victim) == cell_q);
    am        = vrd_q && (tab_rd_q.ftype >= FT_INV) &&
                (CMPW'(tab_rd_q.aggr) == cell_q);

    unique case (state_q)
      S_CLR: begin
        mem_we    = 1'b1;
        mem_wa    = clr_cnt_q;
        mem_wd    = '0;
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == AW'(WORDS - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_acc) state_d = S_EXEC;
      end
      S_EXEC: begin
        case (act_q)
          ACT_LOAD: begin
            if (load_ok && (ent_q.ftype == FT_STUCK)) cop_start = 1'b1;
            else state_d = S_ORD;
          end
          ACT_WRITE: begin
            base_d = CELLW'(addr_q) * CELLW'(WORD_BITS);
            if (addr_ok) begin
              mem_re  = 1'b1;
              state_d = S_WRW;
            end else begin
              res_d   = '0;
              state_d = S_OUT;
            end
          end
          default: state_d = S_ORD;
        endcase
      end
      S_WRW: begin
        old_d   = rdata_q;
        cur_d   = rdata_q;
        b_d     = '0;
        state_d = S_BIT;
      end
      S_BIT: begin
        if (b_q == BCW'(WORD_BITS)) begin
          state_d = S_WB;
        end else if (nv != ov) begin
          cell_d  = CMPW'(base_q) + CMPW'(b_q);
          sc_d    = '0;
          pv_d    = 1'b0;
          vf_d    = 1'b0;
          af_d    = 1'b0;
          state_d = S_SCAN;
        end else begin
          b_d = b_q + 1'b1;
        end
      end
      S_SCAN: begin
        // slot read is registered, compare runs in the cycle after the issue
        if (sc_q != SCW'(FAULT_SLOTS)) begin
          sc_d = sc_q + 1'b1;
          pv_d = 1'b1;
        end else begin
          pv_d = 1'b0;
        end
        if (pv_q && vm && !vf_q) begin
          vf_d   = 1'b1;
          vent_d = tab_rd_q;
        end
        if (pv_q && am && !af_q) begin
          af_d   = 1'b1;
          aent_d = tab_rd_q;
        end
        if ((sc_q == SCW'(FAULT_SLOTS)) && !pv_q) state_d = S_DEC;
      end
      S_DEC: begin
        state_d = S_NEXT;
        wbit_d  = 1'b1;
        if (vf_q) begin
          // bit is a victim: the first such entry gates the write
          case (fault_type_e'(vent_q.ftype)) inside
            FT_TRANS: wbit_d = (ov != vent_q.vval);
            FT_INV, FT_IDEM: wbit_d = 1'b1;
            FT_STATE: begin
              if (nv == vent_q.vval) begin
                cop_start = 1'b1;
                cop_cell  = vent_q.aggr;
                cop_op    = OP_GET;
                cop_ret   = RET_STATE;
              end
            end
            default: wbit_d = 1'b0;
          endcase
        end else if (af_q) begin
          // bit is an aggressor: act on the victim, then write the bit
          cop_cell = aent_q.victim;
          cop_ret  = RET_AGGR;
          case (fault_type_e'(aent_q.ftype))
            FT_INV: begin
              cop_start = (nv == aent_q.aval);
              cop_op    = OP_INV;
            end
            FT_IDEM: begin
              cop_start = (nv == aent_q.aval);
              cop_op    = OP_SET;
              cop_val   = aent_q.vval;
            end
            FT_ADDR: begin
              cop_start = 1'b1;
              cop_op    = OP_SET;
              cop_val   = nv;
            end
            default: cop_start = 1'b0;
          endcase
        end
      end
      S_DIV: begin
        // word index by reciprocal multiply, then bit index from it
        if (dcnt_q == '0) begin
          quo_d  = CELL_W'(prod >> RSH);
          dcnt_d = dcnt_q + 1'b1;
        end else begin
          rem_d   = RW'(sh_q - CELL_W'(quo_q * CELL_W'(WORD_BITS)));
          state_d = S_CLOC;
        end
      end
      S_CLOC: begin
        if (32'(quo_q) >= WORDS) begin
          g        = 1'b0;
          cop_done = 1'b1;
        end else if ((act_q == ACT_WRITE) && (quo_q == CELL_W'(addr_q))) begin
          // cell lies in the word being written: work on the live copy
          g = cur_q[ci];
          case (op_q)
            OP_SET:  cur_d[ci] = opv_q;
            OP_INV:  cur_d[ci] = ~cur_q[ci];
            default: cur_d[ci] = cur_q[ci];
          endcase
          cop_done = 1'b1;
        end else begin
          mem_re  = 1'b1;
          mem_ra  = AW'(quo_q);
          state_d = S_CRD;
        end
      end
      S_CRD: begin
        g = rdata_q[ci];
        if (op_q != OP_GET) begin
          wtmp[ci] = (op_q == OP_INV) ? ~rdata_q[ci] : opv_q;
          mem_we   = 1'b1;
          mem_wa   = AW'(quo_q);
          mem_wd   = wtmp;
        end
        cop_done = 1'b1;
      end
      S_NEXT: begin
        if (wbit_q) cur_d[bi] = nv;
        b_d     = b_q + 1'b1;
        state_d = S_BIT;
      end
      S_WB: begin
        mem_we  = 1'b1;
        mem_wd  = cur_q;
        res_d   = DATA_W'(cur_q);
        state_d = S_OUT;
      end
      S_ORD: begin
        if (addr_ok) begin
          mem_re  = 1'b1;
          state_d = S_ORW;
        end else begin
          res_d   = '0;
          state_d = S_OUT;
        end
      end
      S_ORW: begin
        res_d   = DATA_W'(rdata_q);
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (cop_start) begin
      sh_d    = cop_cell;
      op_d    = cop_op;
      opv_d   = cop_val;
      ret_d   = cop_ret;
      rem_d   = '0;
      quo_d   = '0;
      dcnt_d  = '0;
      state_d = S_DIV;
    end

    if (cop_done) begin
      case (ret_q)
        RET_STATE: begin
          wbit_d  = (g == vent_q.aval);
          state_d = S_NEXT;
        end
        RET_AGGR: begin
          wbit_d  = 1'b1;
          state_d = S_NEXT;
        end
        default: state_d = S_ORD;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_cnt_q   <= '0;
      pv_q        <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < FAULT_SLOTS; i++) vld_q[i] <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
      pv_q      <= pv_d;
      if (out_load) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
      if ((state_q == S_EXEC) && (act_q == ACT_CLEAR)) begin
        for (int i = 0; i < FAULT_SLOTS; i++) vld_q[i] <= 1'b0;
      end else if ((state_q == S_EXEC) && (act_q == ACT_LOAD) && slot_ok) begin
        vld_q[SIW'(slot_q)] <= load_ok;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      act_q        <= act_e'(s_axis_tuser);
      addr_q       <= s_axis_tdata[9:0];
      wd_q         <= WORD_BITS'(s_axis_tdata[25:10]);
      slot_q       <= s_axis_tdata[29:26];
      ent_q.ftype  <= s_axis_tdata[32:30];
      ent_q.victim <= s_axis_tdata[46:33];
      ent_q.vval   <= s_axis_tdata[47];
      ent_q.aggr   <= s_axis_tdata[61:48];
      ent_q.aval   <= s_axis_tdata[62];
    end
    if (out_load) out_data_q <= res_q;
    old_q  <= old_d;
    cur_q  <= cur_d;
    base_q <= base_d;
    cell_q <= cell_d;
    b_q    <= b_d;
    sc_q   <= sc_d;
    vf_q   <= vf_d;
    af_q   <= af_d;
    vent_q <= vent_d;
    aent_q <= aent_d;
    wbit_q <= wbit_d;
    sh_q   <= sh_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    dcnt_q <= dcnt_d;
    op_q   <= op_d;
    opv_q  <= opv_d;
    ret_q  <= ret_d;
    res_q  <= res_d;
  end

  // fault table, one write and one registered read a cycle
  always_ff @(posedge clk_i) begin
    if ((state_q == S_EXEC) && (act_q == ACT_LOAD) && load_ok) tab[SIW'(slot_q)] <= ent_q;
    tab_rd_q <= tab[sc_q[SIW-1:0]];
    vrd_q    <= vld_q[sc_q[SIW-1:0]];
  end

  // single-port word memory with registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) rdata_q <= mem[mem_ra];
  end

endmodule

`default_nettype wire
